/* src/cttt_pkg.sv */
// Shared types and constants of the cooperative task timer table.
`default_nettype none

package cttt_pkg;

    // Table geometry.
    localparam int TASK_SLOTS  = 8;
    localparam int SLOT_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int HANDLE_W  = 16;
    localparam int TIME_W    = 32;
    localparam int INDEX_W   = 3;
    localparam int PEND_W    = 8;
    localparam int KIND_W    = 3;
    localparam int SLOTNUM_W = 4;

    // Slot number reported when no slot is concerned.
    localparam logic [SLOTNUM_W-1:0] NO_SLOT = 4'd8;
    localparam logic [PEND_W-1:0]    PEND_MAX = 8'hFF;

    // Request commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 2'd0,
        CMD_ADD      = 2'd1,
        CMD_DELETE   = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_e;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_ADDED       = 3'd0,
        KIND_FULL        = 3'd1,
        KIND_DELETED     = 3'd2,
        KIND_ZERO_HANDLE = 3'd3,
        KIND_DUE         = 3'd4,
        KIND_NONE_DUE    = 3'd5
    } kind_e;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_e;

    // One slot record as stored in the table memory.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   delay;
        logic [TIME_W-1:0]   period;
        logic [PEND_W-1:0]   pending;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    // One result item.
    typedef struct packed {
        kind_e                kind;
        logic [SLOTNUM_W-1:0] slot;
        logic [HANDLE_W-1:0]  handle;
        logic                 last;
    } result_t;

    // Access request from the sequencer to the table memory.
    typedef struct packed {
        logic              re;
        logic [SLOT_W-1:0] raddr;
        logic              we;
        logic [SLOT_W-1:0] waddr;
        slot_rec_t         wdata;
    } ram_req_t;

endpackage

`default_nettype wire

/* src/cttt_ram.sv */
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module cttt_ram #(
    parameter int DEPTH = 8,
    parameter int WIDTH = 8
) (
    input  wire logic                                     aclk,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    output logic      [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is enabled.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* src/cttt_out_stage.sv */
// Result register that parts the sequencer from the result channel.
`default_nettype none

module cttt_out_stage
    import cttt_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    input  result_t      in_data,
    output logic         in_ready,
    output logic         out_valid,
    output result_t      out_data,
    input  wire logic    out_ready
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // A new result may enter when the register is empty or being drained.
    always_comb begin
        in_ready   = !valid_reg || out_ready;
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

/* src/cttt_ctrl.sv */
// Sequencer: takes requests, scans the slot table and forms results.
`default_nettype none

module cttt_ctrl
    import cttt_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire logic [CMD_W-1:0]    req_cmd,
    input  wire logic [HANDLE_W-1:0] req_handle,
    input  wire logic [TIME_W-1:0]   req_delay,
    input  wire logic [TIME_W-1:0]   req_period,
    input  wire logic [INDEX_W-1:0]  req_index,
    output ram_req_t                 ram_req,
    input  slot_rec_t                ram_rdata,
    output logic                     res_valid,
    output result_t                  res_data,
    input  wire logic                res_ready
);

    state_e                  state_reg, state_next;
    logic                    disp_reg, disp_next;
    logic [TASK_SLOTS-1:0]   occ_reg, occ_next;
    logic [TASK_SLOTS-1:0]   pnz_reg, pnz_next;
    logic [SLOT_W:0]         rd_idx_reg, rd_idx_next;
    logic                    proc_valid_reg, proc_valid_next;
    logic [SLOT_W-1:0]       proc_idx_reg, proc_idx_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    cmd_e                    cmd;
    slot_rec_t               rec;
    slot_rec_t               upd;
    logic                    higher_due;
    logic                    due;
    logic                    stall;
    logic                    cap_hit;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic [SLOT_W-1:0]       del_idx;
    logic                    del_in_range;

    assign cmd = cmd_e'(req_cmd);

    // A free slot's memory contents are stale; it reads as all zero.
    assign rec = occ_reg[proc_idx_reg] ? ram_rdata : '0;

    // Lowest free slot.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (!occ_reg[i] && !free_found) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    // Any slot above the one in hand with pending work.
    always_comb begin
        higher_due = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++) begin
            if (SLOT_W'(i) > proc_idx_reg && pnz_reg[i]) begin
                higher_due = 1'b1;
            end
        end
    end

    assign del_idx      = SLOT_W'(req_index);
    assign del_in_range = 32'(req_index) < TASK_SLOTS;
    assign due          = disp_reg && proc_valid_reg && pnz_reg[proc_idx_reg];
    assign stall        = due && !res_ready;
    assign cap_hit      = disp_reg && (cnt_reg == CNT_W'(MAX_RESULTS));

    // Next state, memory accesses and results.
    always_comb begin
        state_next      = state_reg;
        disp_next       = disp_reg;
        occ_next        = occ_reg;
        pnz_next        = pnz_reg;
        rd_idx_next     = rd_idx_reg;
        proc_valid_next = proc_valid_reg;
        proc_idx_next   = proc_idx_reg;
        cnt_next        = cnt_reg;
        ram_req         = '0;
        res_valid       = 1'b0;
        res_data        = '0;
        req_ready       = 1'b0;
        upd             = rec;

        unique case (state_reg)
            ST_IDLE: begin
                req_ready = res_ready;
                if (req_valid && res_ready) begin
                    res_data.last = 1'b1;
                    res_data.slot = NO_SLOT;
                    unique case (cmd)
                        CMD_TICK: begin
                            state_next      = ST_SCAN;
                            disp_next       = 1'b0;
                            rd_idx_next     = '0;
                            proc_valid_next = 1'b0;
                            cnt_next        = '0;
                        end
                        CMD_ADD: begin
                            res_valid = 1'b1;
                            if (req_handle == '0) begin
                                res_data.kind = KIND_ZERO_HANDLE;
                            end else if (!free_found) begin
                                res_data.kind = KIND_FULL;
                            end else begin
                                ram_req.we            = 1'b1;
                                ram_req.waddr         = free_idx;
                                ram_req.wdata.handle  = req_handle;
                                ram_req.wdata.delay   = req_delay;
                                ram_req.wdata.period  = req_period;
                                ram_req.wdata.pending = '0;
                                occ_next[free_idx]    = 1'b1;
                                pnz_next[free_idx]    = 1'b0;
                                res_data.kind         = KIND_ADDED;
                                res_data.slot         = SLOTNUM_W'(free_idx);
                            end
                        end
                        CMD_DELETE: begin
                            res_valid     = 1'b1;
                            res_data.kind = KIND_DELETED;
                            res_data.slot = SLOTNUM_W'(req_index);
                            // Clearing occupancy makes the entry read as zero.
                            if (del_in_range) begin
                                occ_next[del_idx] = 1'b0;
                                pnz_next[del_idx] = 1'b0;
                            end
                        end
                        CMD_DISPATCH: begin
                            if (pnz_reg == '0) begin
                                res_valid     = 1'b1;
                                res_data.kind = KIND_NONE_DUE;
                            end else begin
                                state_next      = ST_SCAN;
                                disp_next       = 1'b1;
                                rd_idx_next     = '0;
                                proc_valid_next = 1'b0;
                                cnt_next        = '0;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN: begin
                if (cap_hit) begin
                    // Result limit reached; later slots keep their work.
                    state_next      = ST_IDLE;
                    proc_valid_next = 1'b0;
                end else if (!stall) begin
                    // Finish the slot whose record arrived this cycle.
                    if (proc_valid_reg) begin
                        if (disp_reg) begin
                            if (pnz_reg[proc_idx_reg]) begin
                                res_valid       = 1'b1;
                                res_data.kind   = KIND_DUE;
                                res_data.slot   = SLOTNUM_W'(proc_idx_reg);
                                res_data.handle = rec.handle;
                                res_data.last   = !higher_due ||
                                                  (cnt_reg == CNT_W'(MAX_RESULTS - 1));
                                cnt_next        = cnt_reg + CNT_W'(1);
                                if (rec.period == '0) begin
                                    occ_next[proc_idx_reg] = 1'b0;
                                    pnz_next[proc_idx_reg] = 1'b0;
                                end else begin
                                    upd.pending   = rec.pending - PEND_W'(1);
                                    ram_req.we    = 1'b1;
                                    ram_req.waddr = proc_idx_reg;
                                    ram_req.wdata = upd;
                                    pnz_next[proc_idx_reg] = (rec.pending != PEND_W'(1));
                                end
                            end
                        end else if (occ_reg[proc_idx_reg]) begin
                            if (rec.delay == '0) begin
                                if (rec.pending != PEND_MAX) begin
                                    upd.pending = rec.pending + PEND_W'(1);
                                end
                                if (rec.period != '0) begin
                                    upd.delay = rec.period;
                                end
                                pnz_next[proc_idx_reg] = 1'b1;
                            end else begin
                                upd.delay = rec.delay - TIME_W'(1);
                            end
                            ram_req.we    = 1'b1;
                            ram_req.waddr = proc_idx_reg;
                            ram_req.wdata = upd;
                        end
                    end

                    // Fetch the next slot, or end after the last one.
                    if (rd_idx_reg == (SLOT_W + 1)'(TASK_SLOTS)) begin
                        state_next      = ST_IDLE;
                        proc_valid_next = 1'b0;
                    end else begin
                        ram_req.re      = 1'b1;
                        ram_req.raddr   = rd_idx_reg[SLOT_W-1:0];
                        proc_valid_next = 1'b1;
                        proc_idx_next   = rd_idx_reg[SLOT_W-1:0];
                        rd_idx_next     = rd_idx_reg + (SLOT_W + 1)'(1);
                    end
                end
            end

            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            pnz_reg        <= '0;
            proc_valid_reg <= 1'b0;
            disp_reg       <= 1'b0;
            rd_idx_reg     <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            occ_reg        <= occ_next;
            pnz_reg        <= pnz_next;
            proc_valid_reg <= proc_valid_next;
            disp_reg       <= disp_next;
            rd_idx_reg     <= rd_idx_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        proc_idx_reg <= proc_idx_next;
    end

    // Pending work is only ever held by an occupied slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pnz_reg & ~occ_reg) == '0)
        else $error("pending flag set on a free slot");

    // The scan never writes the entry it is reading in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_req.we && ram_req.re && (ram_req.waddr == ram_req.raddr)))
        else $error("read and write to the same slot in one cycle");

    // A result is only offered when the result register can take it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> res_ready)
        else $error("result pushed into a full result register");

    // The slot in hand is always the one fetched just before.
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_valid_reg |-> (rd_idx_reg == {1'b0, proc_idx_reg} + (SLOT_W + 1)'(1)))
        else $error("scan fetch and process indexes out of step");

endmodule

`default_nettype wire

/* src/cooperative_task_timer_table_unit.sv */
// Top level of the cooperative task timer table.
// Add, delete and a dispatch with nothing due give their result in the cycle after
// the request is accepted, one such request a cycle while the result register can take
// it. Tick and dispatch scan the table memory one slot a cycle, pausing while a due
// result waits on the result register, and take no new request until the scan ends.
// Reset clears occupancy and pending flags at once; the memory is not cleared, free
// slots read as zero, so no clearing pass follows reset.
`default_nettype none

module cooperative_task_timer_table_unit
    import cttt_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [CMD_W-1:0]     s_cmd,
    input  wire logic [HANDLE_W-1:0]  s_task_handle,
    input  wire logic [TIME_W-1:0]    s_start_delay,
    input  wire logic [TIME_W-1:0]    s_repeat_period,
    input  wire logic [INDEX_W-1:0]   s_slot_index,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [KIND_W-1:0]         m_result_kind,
    output logic [SLOTNUM_W-1:0]      m_slot_number,
    output logic [HANDLE_W-1:0]       m_due_handle,
    output logic                      m_last_of_run
);

    ram_req_t          ram_req;
    logic [REC_W-1:0]  ram_rdata;
    logic              res_valid;
    result_t           res_data;
    logic              res_ready;
    result_t           out_data;

    // Request sequencer.
    cttt_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_valid),
        .req_ready  (s_ready),
        .req_cmd    (s_cmd),
        .req_handle (s_task_handle),
        .req_delay  (s_start_delay),
        .req_period (s_repeat_period),
        .req_index  (s_slot_index),
        .ram_req    (ram_req),
        .ram_rdata  (slot_rec_t'(ram_rdata)),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_ready  (res_ready)
    );

    // Slot table memory.
    cttt_ram #(
        .DEPTH (TASK_SLOTS),
        .WIDTH (REC_W)
    ) u_ram (
        .aclk  (aclk),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // Result register.
    cttt_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res_data),
        .in_ready  (res_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_result_kind = out_data.kind;
    assign m_slot_number = out_data.slot;
    assign m_due_handle  = out_data.handle;
    assign m_last_of_run = out_data.last;

endmodule

`default_nettype wire
